### src/ufnc_pkg.sv
package ufnc_pkg;

	localparam int NODE_W  = 6;
	localparam int SIZE_W  = 7;
	localparam int COST_W  = 53;
	localparam int TOTAL_W = 63;
	localparam int FUNC_W  = 2;

	localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

	// operation codes
	localparam logic [FUNC_W-1:0] FUNC_LOAD   = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_EDGE   = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_REPORT = 2'd2;

	typedef logic [NODE_W-1:0]  node_id_t;
	typedef logic [SIZE_W-1:0]  set_size_t;
	typedef logic [COST_W-1:0]  cost_t;
	typedef logic [TOTAL_W-1:0] total_t;

	// one entry of the node memory
	typedef struct packed {
		node_id_t  parent;
		set_size_t size;
		node_id_t  best;
	} node_word_t;

endpackage

### src/ufnc_if.sv
interface ufnc_req_if;
	import ufnc_pkg::*;

	logic                    valid;
	logic                    ready;
	logic [FUNC_W-1:0]       func;
	logic [NODE_W-1:0]       node_a;
	logic [NODE_W-1:0]       node_b;
	logic [COST_W-1:0]       amount;

	modport source (output valid, func, node_a, node_b, amount, input ready);
	modport sink   (input valid, func, node_a, node_b, amount, output ready);
endinterface

interface ufnc_rsp_if;
	import ufnc_pkg::*;

	logic                    valid;
	logic                    ready;
	logic                    edge_taken;
	logic [NODE_W-1:0]       station_node;
	logic                    new_station;
	logic [TOTAL_W-1:0]      total_cost;

	modport source (output valid, edge_taken, station_node, new_station, total_cost,
		input ready);
	modport sink   (input valid, edge_taken, station_node, new_station, total_cost,
		output ready);
endinterface

### src/union_find_merge_with_node_cost_top.sv
// Union-find engine for a Kruskal forest with per-node station costs. Each request item
// carries func: load a station cost (0), offer an edge in ascending cost order (1), or
// report the best station of a node's set (2); every item yields exactly one result item
// with the running, saturating total. Work is sequential, one item at a time: req.ready is
// high only while the engine is idle. An edge walks node_a and then node_b to their roots,
// reads the best station cost of each set, compares the two, checks the larger against
// the edge cost and, if the edge is taken, relinks the smaller root and updates the larger.
// An edge whose ends already share a set, or that names a node beyond NODES, goes straight
// to the result. Union by size keeps chains at most log2(NODES) links. A report walks to
// the root and reads its best station's cost. Work is paced by the single read port of the
// node memory, which the root walks use one link a cycle, and by one shared 53-bit comparator
// used for three compares in turn. Node memory entries not yet written read as their reset
// value through a row of valid flops, so no clearing pass is needed after reset. An unused
// func code returns the current total.
module union_find_merge_with_node_cost_top
	import ufnc_pkg::*;
#(
	parameter int NODES = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	ufnc_req_if.sink   req,
	ufnc_rsp_if.source rsp
);

	localparam int AW = (NODES > 1) ? $clog2(NODES) : 1;
	localparam logic [NODE_W:0] NODES_L = (NODE_W+1)'(NODES);

	typedef enum logic [3:0] {
		S_IDLE,
		S_FA,   // walk to root of node_a
		S_FB,   // walk to root of node_b
		S_CA,   // cost of node_a set best arrives
		S_CB,   // cost of node_b set best arrives
		S_C1,   // ca < cb
		S_C2,   // cb < ca
		S_C3,   // edge cost against larger best cost
		S_M1,   // relink smaller root
		S_M2,   // update larger root, add edge cost
		S_FR,   // walk to root for report
		S_RC,   // station cost arrives for report
		S_OUT
	} state_t;

	state_t state_q;

	// latched request
	node_id_t          nb_q;
	cost_t             amt_q;

	// roots and set data of both ends
	node_id_t  ra_q, rb_q;
	set_size_t size_a_q, size_b_q;
	node_id_t  best_a_q, best_b_q;
	cost_t     ca_q, cb_q;
	logic      a_lt_b_q, b_lt_a_q;

	// result
	logic     taken_q;
	node_id_t snode_q;
	logic     fresh_q;
	total_t   total_q;

	// node memory: parent, size, best station
	node_word_t       node_mem [NODES];
	logic [NODES-1:0] node_vld_q;
	node_word_t       node_rd_q;
	logic             node_rd_vld_q;
	node_id_t         node_rd_addr_q;
	node_id_t         node_rd_addr;
	node_word_t       node_w;
	logic             node_we;
	node_id_t         node_wr_addr;
	node_word_t       node_wr_word;

	// station cost memory, no reset value
	cost_t    cost_mem [NODES];
	cost_t    cost_rd_q;
	node_id_t cost_rd_addr;
	logic     cost_we;

	logic [NODES-1:0] reported_q;

	// shared comparator and saturating adder
	cost_t             cmp_x, cmp_y;
	logic              cmp_lt;
	cost_t             add_val;
	logic [TOTAL_W:0]  add_sum;
	total_t            add_sat;

	logic     req_fire;
	logic     na_ok, nb_ok;
	logic     is_root;
	logic     a_small;
	node_id_t big_root, small_root;
	logic     small_cheaper;

	assign req_fire = req.valid && req.ready;
	assign na_ok    = {1'b0, req.node_a} < NODES_L;
	assign nb_ok    = {1'b0, req.node_b} < NODES_L;

	// entries never written read as their reset value
	always_comb begin
		if (node_rd_vld_q) begin
			node_w = node_rd_q;
		end else begin
			node_w.parent = node_rd_addr_q;
			node_w.size   = set_size_t'(1);
			node_w.best   = node_rd_addr_q;
		end
	end

	assign is_root = (node_w.parent == node_rd_addr_q);

	// union by size: node_a's root stays root on a tie
	assign a_small       = size_a_q < size_b_q;
	assign big_root      = a_small ? rb_q : ra_q;
	assign small_root    = a_small ? ra_q : rb_q;
	assign small_cheaper = a_small ? a_lt_b_q : b_lt_a_q;

	always_comb begin
		case (state_q)
			S_C1: begin
				cmp_x = ca_q;
				cmp_y = cb_q;
			end
			S_C2: begin
				cmp_x = cb_q;
				cmp_y = ca_q;
			end
			default: begin
				cmp_x = a_lt_b_q ? cb_q : ca_q;
				cmp_y = amt_q;
			end
		endcase
	end
	assign cmp_lt = cmp_x < cmp_y;

	assign add_val = (state_q == S_RC) ? cost_rd_q : amt_q;
	assign add_sum = {1'b0, total_q} + (TOTAL_W+1)'(add_val);
	assign add_sat = add_sum[TOTAL_W] ? TOTAL_MAX : add_sum[TOTAL_W-1:0];

	// node memory read address
	always_comb begin
		case (state_q)
			S_IDLE: node_rd_addr = req.node_a;
			S_FA:   node_rd_addr = is_root ? nb_q : node_w.parent;
			S_FB:   node_rd_addr = node_w.parent;
			S_FR:   node_rd_addr = node_w.parent;
			default: node_rd_addr = node_rd_addr_q;
		endcase
	end

	// node memory write
	always_comb begin
		node_we      = 1'b0;
		node_wr_addr = small_root;
		node_wr_word = '{parent: big_root, size: (a_small ? size_a_q : size_b_q),
			best: (a_small ? best_a_q : best_b_q)};
		case (state_q)
			S_M1: begin
				node_we = 1'b1;
			end
			S_M2: begin
				node_we           = 1'b1;
				node_wr_addr      = big_root;
				node_wr_word.size = size_a_q + size_b_q;
				if (small_cheaper) begin
					node_wr_word.best = a_small ? best_a_q : best_b_q;
				end else begin
					node_wr_word.best = a_small ? best_b_q : best_a_q;
				end
			end
			default: begin
				node_we = 1'b0;
			end
		endcase
	end

	// cost memory read address
	always_comb begin
		case (state_q)
			S_FB:   cost_rd_addr = best_a_q;
			S_CA:   cost_rd_addr = best_b_q;
			default: cost_rd_addr = node_w.best;
		endcase
	end

	assign cost_we = req_fire && (req.func == FUNC_LOAD) && na_ok;

	always_ff @(posedge clk) begin
		if (node_we) begin
			node_mem[node_wr_addr[AW-1:0]] <= node_wr_word;
		end
		node_rd_q      <= node_mem[node_rd_addr[AW-1:0]];
		node_rd_addr_q <= node_rd_addr;
	end

	always_ff @(posedge clk) begin
		if (cost_we) begin
			cost_mem[req.node_a[AW-1:0]] <= req.amount;
		end
		cost_rd_q <= cost_mem[cost_rd_addr[AW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_vld_q    <= '0;
			node_rd_vld_q <= 1'b0;
		end else begin
			if (node_we) begin
				node_vld_q[node_wr_addr[AW-1:0]] <= 1'b1;
			end
			node_rd_vld_q <= node_vld_q[node_rd_addr[AW-1:0]];
		end
	end

	// sequencer and result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			taken_q    <= 1'b0;
			snode_q    <= '0;
			fresh_q    <= 1'b0;
			total_q    <= '0;
			reported_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (req_fire) begin
						nb_q    <= req.node_b;
						amt_q   <= req.amount;
						taken_q <= 1'b0;
						snode_q <= '0;
						fresh_q <= 1'b0;
						case (req.func)
							FUNC_EDGE: state_q <= (na_ok && nb_ok) ? S_FA : S_OUT;
							FUNC_REPORT: state_q <= na_ok ? S_FR : S_OUT;
							default: state_q <= S_OUT;
						endcase
					end
				end
				S_FA: begin
					if (is_root) begin
						ra_q     <= node_rd_addr_q;
						size_a_q <= node_w.size;
						best_a_q <= node_w.best;
						state_q  <= S_FB;
					end
				end
				S_FB: begin
					if (is_root) begin
						rb_q     <= node_rd_addr_q;
						size_b_q <= node_w.size;
						best_b_q <= node_w.best;
						state_q  <= (node_rd_addr_q == ra_q) ? S_OUT : S_CA;
					end
				end
				S_CA: begin
					ca_q    <= cost_rd_q;
					state_q <= S_CB;
				end
				S_CB: begin
					cb_q    <= cost_rd_q;
					state_q <= S_C1;
				end
				S_C1: begin
					a_lt_b_q <= cmp_lt;
					state_q  <= S_C2;
				end
				S_C2: begin
					b_lt_a_q <= cmp_lt;
					state_q  <= S_C3;
				end
				S_C3: begin
					// larger best cost below the edge cost: reject
					state_q <= cmp_lt ? S_OUT : S_M1;
				end
				S_M1: begin
					state_q <= S_M2;
				end
				S_M2: begin
					total_q <= add_sat;
					taken_q <= 1'b1;
					state_q <= S_OUT;
				end
				S_FR: begin
					if (is_root) begin
						snode_q <= node_w.best;
						state_q <= S_RC;
					end
				end
				S_RC: begin
					if (!reported_q[snode_q[AW-1:0]]) begin
						reported_q[snode_q[AW-1:0]] <= 1'b1;
						total_q <= add_sat;
						fresh_q <= 1'b1;
					end
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (rsp.ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign req.ready        = (state_q == S_IDLE);
	assign rsp.valid        = (state_q == S_OUT);
	assign rsp.edge_taken   = taken_q;
	assign rsp.station_node = snode_q;
	assign rsp.new_station  = fresh_q;
	assign rsp.total_cost   = total_q;

endmodule

### src/ufnc_chk.sv
module ufnc_chk
	import ufnc_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               req_valid,
	input logic               req_ready,
	input logic               rsp_valid,
	input logic               rsp_ready,
	input logic               edge_taken,
	input logic               new_station,
	input logic [TOTAL_W-1:0] total_cost
);

	logic [TOTAL_W-1:0] last_total_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_total_q <= '0;
		end else if (rsp_valid && rsp_ready) begin
			last_total_q <= total_cost;
		end
	end

	// one item in flight: never taking a new item while a result waits
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(req_ready && rsp_valid))
		else $error("request ready while result pending");

	// busy right after an item is taken
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready) |=> !req_ready)
		else $error("ready right after accepting an item");

	// a taken result is not repeated
	a_single_result: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp_ready) |=> !rsp_valid)
		else $error("result repeated");

	// running total never decreases
	a_total_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (total_cost >= last_total_q))
		else $error("total cost decreased");

	// an edge result never reports a station
	a_result_kind: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> !(edge_taken && new_station))
		else $error("edge and station flagged together");

endmodule

bind union_find_merge_with_node_cost_top ufnc_chk u_ufnc_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.req_valid   (req.valid),
	.req_ready   (req.ready),
	.rsp_valid   (rsp.valid),
	.rsp_ready   (rsp.ready),
	.edge_taken  (rsp.edge_taken),
	.new_station (rsp.new_station),
	.total_cost  (rsp.total_cost)
);
